>>> hdl/hufd_pkg.sv
package hufd_pkg;

  // Field widths of the request and result items.
  localparam int IDXW      = 9;
  localparam int SYMW      = 8;
  localparam int CNTW      = 31;
  localparam int BYTE_BITS = 8;
  localparam int BITSELW   = 3;
  localparam int NBITW     = 4;

  // Default node table size.
  localparam int MAX_NODES_DEF = 512;

  // Queue depths (powers of two).
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 4;

  // Request opcodes.
  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Configuration port.
  localparam int CFG_IDXW = 1;
  localparam int CFG_DW   = 31;
  localparam logic [CFG_IDXW-1:0] REG_ROOT  = 1'd0;
  localparam logic [CFG_IDXW-1:0] REG_TOTAL = 1'd1;

  // One node table entry.
  typedef struct packed {
    logic            leaf;
    logic [SYMW-1:0] sym;
    logic [IDXW-1:0] kid0;
    logic [IDXW-1:0] kid1;
  } node_t;

  // Classification of an accepted request.
  typedef enum logic [1:0] {
    K_DECODE = 2'd0,
    K_LOAD   = 2'd1,
    K_SKIP   = 2'd2
  } kind_e;

  // Classified request handed from the front to the back.
  typedef struct packed {
    kind_e           kind;
    logic [SYMW-1:0] data_byte;
    logic [IDXW-1:0] idx;
    node_t           node;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [SYMW-1:0] sym;
    logic            last;
    logic            done;
  } res_t;

endpackage

>>> hdl/hufd_fifo.sv
module hufd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_en_i,
  input  logic [W-1:0] wr_data_i,
  output logic         full_o,
  input  logic         rd_en_i,
  output logic [W-1:0] rd_data_o,
  output logic         vld_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          do_wr, do_rd;

  assign full_o    = (cnt_q == (AW+1)'(DEPTH));
  assign vld_o     = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & vld_o;

  // Pointer and fill count update, wrapping at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> hdl/hufd_front.sv
module hufd_front #(
  parameter int MAX_NODES = hufd_pkg::MAX_NODES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic                       op_i,
  input  logic [hufd_pkg::SYMW-1:0]  packed_byte_i,
  input  logic [hufd_pkg::IDXW-1:0]  node_index_i,
  input  logic                       node_is_leaf_i,
  input  logic [hufd_pkg::SYMW-1:0]  node_symbol_i,
  input  logic [hufd_pkg::IDXW-1:0]  left_index_i,
  input  logic [hufd_pkg::IDXW-1:0]  right_index_i,
  output logic                       cmd_vld_o,
  output hufd_pkg::cmd_t             cmd_o,
  input  logic                       cmd_pop_i
);

  localparam logic [hufd_pkg::IDXW:0] NODE_LIM = (hufd_pkg::IDXW+1)'(MAX_NODES);

  hufd_pkg::cmd_t cmd_in;
  logic           in_range;

  // Classify the request: decode, table load, or a load beyond the table.
  assign in_range = ({1'b0, node_index_i} < NODE_LIM);

  always_comb begin
    cmd_in.data_byte = packed_byte_i;
    cmd_in.idx       = node_index_i;
    cmd_in.node.leaf = node_is_leaf_i;
    cmd_in.node.sym  = node_symbol_i;
    cmd_in.node.kid0 = left_index_i;
    cmd_in.node.kid1 = right_index_i;
    if (op_i == hufd_pkg::OP_DECODE) begin
      cmd_in.kind = hufd_pkg::K_DECODE;
    end else if (in_range) begin
      cmd_in.kind = hufd_pkg::K_LOAD;
    end else begin
      cmd_in.kind = hufd_pkg::K_SKIP;
    end
  end

  // Short queue towards the tree walker.
  hufd_fifo #(
    .W     ($bits(hufd_pkg::cmd_t)),
    .DEPTH (hufd_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push_i),
    .wr_data_i (cmd_in),
    .full_o    (full_o),
    .rd_en_i   (cmd_pop_i),
    .rd_data_o (cmd_o),
    .vld_o     (cmd_vld_o)
  );

endmodule

>>> hdl/hufd_back.sv
module hufd_back #(
  parameter int MAX_NODES = hufd_pkg::MAX_NODES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hufd_pkg::CFG_IDXW-1:0] cfg_idx_i,
  input  logic [hufd_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                          cmd_vld_i,
  input  hufd_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  output logic                          res_push_o,
  output hufd_pkg::res_t                res_o,
  input  logic                          res_full_i
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [hufd_pkg::IDXW:0] NODE_LIM = (hufd_pkg::IDXW+1)'(MAX_NODES);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    RD_NONE   = 2'd0,
    RD_CURSOR = 2'd1,
    RD_CHILD  = 2'd2
  } rd_e;

  state_e                        state_q, state_d;
  rd_e                           rd_kind_q, rd_kind_d;
  logic [hufd_pkg::SYMW-1:0]     byte_q;
  logic [hufd_pkg::NBITW-1:0]    nbit_q;
  logic [hufd_pkg::IDXW-1:0]     cursor_q, root_q;
  logic [hufd_pkg::CNTW-1:0]     total_q, count_q;
  hufd_pkg::node_t               ent_q, root_ent_q, rd_q;
  logic                          ent_vld_q, root_vld_q, rd_oor_q;
  hufd_pkg::res_t                pend_q;
  logic                          pend_vld_q;

  // Node table.
  hufd_pkg::node_t               mem_q [MAX_NODES];

  hufd_pkg::node_t               rd_ent, cur_ent;
  logic                          arrive, fetched, leaf_hit, hit_done, final_step, stall;
  logic                          cur_ok, bit_val, issue_child, issue_fetch, rd_en;
  logic [hufd_pkg::IDXW-1:0]     cur_idx, child, rd_addr;
  logic [hufd_pkg::CNTW-1:0]     cnt_inc;
  logic [hufd_pkg::BITSELW-1:0]  bit_pos;
  logic                          walk, flush, idle;

  assign walk  = (state_q == S_WALK);
  assign flush = (state_q == S_FLUSH);
  assign idle  = (state_q == S_IDLE);

  // Entries beyond the table read as all zero.
  assign rd_ent = rd_oor_q ? '0 : rd_q;

  // Evaluate the node that the previous read brought in.
  assign arrive     = walk && (rd_kind_q == RD_CHILD);
  assign fetched    = walk && (rd_kind_q == RD_CURSOR);
  assign leaf_hit   = arrive && rd_ent.leaf;
  assign cnt_inc    = count_q + hufd_pkg::CNTW'(1);
  assign hit_done   = (cnt_inc >= total_q);
  assign stall      = leaf_hit && pend_vld_q && res_full_i;
  assign final_step = (leaf_hit && hit_done) ||
                      (arrive && (nbit_q == hufd_pkg::NBITW'(hufd_pkg::BYTE_BITS)));

  // Entry of the node the cursor rests on after this cycle's evaluation.
  always_comb begin
    if (leaf_hit) begin
      cur_ok  = root_vld_q;
      cur_ent = root_ent_q;
      cur_idx = root_q;
    end else if (arrive || fetched) begin
      cur_ok  = 1'b1;
      cur_ent = rd_ent;
      cur_idx = cursor_q;
    end else begin
      cur_ok  = ent_vld_q;
      cur_ent = ent_q;
      cur_idx = cursor_q;
    end
  end

  // Next bit of the byte, most significant first, chooses the child.
  assign bit_pos     = hufd_pkg::BITSELW'(hufd_pkg::BYTE_BITS-1) - nbit_q[hufd_pkg::BITSELW-1:0];
  assign bit_val     = byte_q[bit_pos];
  assign child       = bit_val ? cur_ent.kid1 : cur_ent.kid0;
  assign issue_child = walk && !stall && !final_step && cur_ok &&
                       (nbit_q != hufd_pkg::NBITW'(hufd_pkg::BYTE_BITS));
  assign issue_fetch = walk && !stall && !final_step && !cur_ok;
  assign rd_en       = issue_child || issue_fetch;
  assign rd_addr     = issue_child ? child : cur_idx;
  assign rd_kind_d   = issue_child ? RD_CHILD : (issue_fetch ? RD_CURSOR : RD_NONE);

  // The held result goes out as not last when a newer one replaces it,
  // and as last when the request ends.
  assign cmd_pop_o  = idle;
  assign res_push_o = (leaf_hit && pend_vld_q && !stall) || (flush && !res_full_i);
  always_comb begin
    res_o      = pend_q;
    res_o.last = flush;
  end

  // Sequencer state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_vld_i && (cmd_i.kind == hufd_pkg::K_DECODE) && (count_q < total_q)) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (!stall && final_step) begin
          state_d = (pend_vld_q || leaf_hit) ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!res_full_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_kind_q  <= RD_NONE;
      nbit_q     <= '0;
      cursor_q   <= '0;
      root_q     <= '0;
      total_q    <= '0;
      count_q    <= '0;
      ent_vld_q  <= 1'b0;
      root_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (idle) begin
        // Start a decode or apply a table load.
        if (cmd_vld_i && (cmd_i.kind == hufd_pkg::K_DECODE)) begin
          nbit_q    <= '0;
          rd_kind_q <= RD_NONE;
        end
        if (cmd_vld_i && (cmd_i.kind == hufd_pkg::K_LOAD)) begin
          if (cmd_i.idx == root_q) begin
            root_vld_q <= 1'b0;
          end
          if (cmd_i.idx == cursor_q) begin
            ent_vld_q <= 1'b0;
          end
        end
      end else if (walk && !stall) begin
        // One tree step.
        rd_kind_q <= rd_kind_d;
        cursor_q  <= issue_child ? child : cur_idx;
        ent_vld_q <= cur_ok;
        if (issue_child) begin
          nbit_q <= nbit_q + hufd_pkg::NBITW'(1);
        end
        if ((arrive || fetched) && (cursor_q == root_q)) begin
          root_vld_q <= 1'b1;
        end
        if (leaf_hit) begin
          count_q    <= cnt_inc;
          pend_vld_q <= 1'b1;
        end
      end else if (flush && !res_full_i) begin
        pend_vld_q <= 1'b0;
      end
      // Configuration writes must arrive only while idle; the block itself does not enforce it.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hufd_pkg::REG_ROOT: begin
            root_q     <= cfg_data_i[hufd_pkg::IDXW-1:0];
            cursor_q   <= cfg_data_i[hufd_pkg::IDXW-1:0];
            ent_vld_q  <= 1'b0;
            root_vld_q <= 1'b0;
          end
          hufd_pkg::REG_TOTAL: begin
            total_q <= cfg_data_i[hufd_pkg::CNTW-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (idle && cmd_vld_i && (cmd_i.kind == hufd_pkg::K_DECODE)) begin
      byte_q <= cmd_i.data_byte;
    end
    if (walk && !stall) begin
      ent_q <= cur_ent;
      if ((arrive || fetched) && (cursor_q == root_q)) begin
        root_ent_q <= rd_ent;
      end
      if (leaf_hit) begin
        pend_q.sym  <= rd_ent.sym;
        pend_q.last <= 1'b0;
        pend_q.done <= hit_done;
      end
    end
  end

  // Node table: written by loads, read at most once per tree step.
  always_ff @(posedge clk_i) begin
    if (idle && cmd_vld_i && (cmd_i.kind == hufd_pkg::K_LOAD)) begin
      mem_q[cmd_i.idx[AW-1:0]] <= cmd_i.node;
    end
    if (rd_en) begin
      rd_q     <= mem_q[rd_addr[AW-1:0]];
      rd_oor_q <= !({1'b0, rd_addr} < NODE_LIM);
    end
  end

endmodule

>>> hdl/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder: one node table read per bit of the packed byte, plus
// a fetch of the cursor entry when it is not cached and of the root entry after each
// leaf while the root entry is not cached; reaching the total ends a request sooner.
// The walker takes the next decode byte only once it is done with the last one, and
// applies table loads only while idle. Reset clears the queues, count, root and total.
module huffman_tree_walk_decoder #(
  parameter int MAX_NODES = hufd_pkg::MAX_NODES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  input  logic                          cfg_we_i,
  input  logic [hufd_pkg::CFG_IDXW-1:0] cfg_idx_i,
  input  logic [hufd_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                          op_i,
  input  logic [hufd_pkg::SYMW-1:0]     packed_byte_i,
  input  logic [hufd_pkg::IDXW-1:0]     node_index_i,
  input  logic                          node_is_leaf_i,
  input  logic [hufd_pkg::SYMW-1:0]     node_symbol_i,
  input  logic [hufd_pkg::IDXW-1:0]     left_index_i,
  input  logic [hufd_pkg::IDXW-1:0]     right_index_i,
  output logic [hufd_pkg::SYMW-1:0]     symbol_o,
  output logic                          last_o,
  output logic                          done_res_o
);

  hufd_pkg::cmd_t cmd;
  logic           cmd_vld, cmd_pop;
  hufd_pkg::res_t res_in, res_out;
  logic           res_push, res_full, res_vld;

  // Front: accepts and classifies requests.
  hufd_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .op_i           (op_i),
    .packed_byte_i  (packed_byte_i),
    .node_index_i   (node_index_i),
    .node_is_leaf_i (node_is_leaf_i),
    .node_symbol_i  (node_symbol_i),
    .left_index_i   (left_index_i),
    .right_index_i  (right_index_i),
    .cmd_vld_o      (cmd_vld),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  // Back: node table and tree walk.
  hufd_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_vld_i  (cmd_vld),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  // Result queue.
  hufd_fifo #(
    .W     ($bits(hufd_pkg::res_t)),
    .DEPTH (hufd_pkg::RESQ_DEPTH)
  ) u_resq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (res_in),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (res_out),
    .vld_o     (res_vld)
  );

  assign empty      = ~res_vld;
  assign symbol_o   = res_out.sym;
  assign last_o     = res_out.last;
  assign done_res_o = res_out.done;

endmodule

>>> hdl/hufd_checker.sv
module hufd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          push,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [hufd_pkg::SYMW-1:0]     symbol_o,
  input logic                          last_o,
  input logic                          done_res_o
);

  // While reset is held both queues read as empty.
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("queues not clear during reset");

  // A waiting result that is not taken stays put.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(symbol_o) && $stable(last_o) &&
                          $stable(done_res_o)))
    else $error("waiting result changed");

  // Reaching the total ends the request, so that result closes it.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && done_res_o) |-> last_o)
    else $error("done result not marked last");

  // The input queue only fills through a request.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("input queue filled without a request");

endmodule

bind huffman_tree_walk_decoder hufd_checker u_hufd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .symbol_o   (symbol_o),
  .last_o     (last_o),
  .done_res_o (done_res_o)
);

>>> sim/tb_huffman_tree_walk_decoder.sv
`timescale 1ns / 1ps

module tb_huffman_tree_walk_decoder;

  // Limits of the decoder.
  localparam logic [hufd_pkg::CNTW-1:0] CNT_MAX = 31'h7FFF_FFFF;
  localparam int TABLE_SIZE    = hufd_pkg::MAX_NODES_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_REPORTS   = 10;

  // One request as seen on the input side.
  typedef struct {
    logic                      op;
    logic [hufd_pkg::SYMW-1:0] data_byte;
    logic [hufd_pkg::IDXW-1:0] idx;
    logic                      leaf;
    logic [hufd_pkg::SYMW-1:0] sym;
    logic [hufd_pkg::IDXW-1:0] kid0;
    logic [hufd_pkg::IDXW-1:0] kid1;
  } tree_req_t;

  logic                          clk_i;
  logic                          rst_ni = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  logic                          empty;
  logic                          pop = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [hufd_pkg::CFG_IDXW-1:0] cfg_idx_i = hufd_pkg::REG_ROOT;
  logic [hufd_pkg::CFG_DW-1:0]   cfg_data_i = '0;
  logic                          op_i = hufd_pkg::OP_DECODE;
  logic [hufd_pkg::SYMW-1:0]     packed_byte_i = '0;
  logic [hufd_pkg::IDXW-1:0]     node_index_i = '0;
  logic                          node_is_leaf_i = 1'b0;
  logic [hufd_pkg::SYMW-1:0]     node_symbol_i = '0;
  logic [hufd_pkg::IDXW-1:0]     left_index_i = '0;
  logic [hufd_pkg::IDXW-1:0]     right_index_i = '0;
  logic [hufd_pkg::SYMW-1:0]     symbol_o;
  logic                          last_o;
  logic                          done_res_o;

  // Shadow copy of the decoder state.
  hufd_pkg::node_t           tree_mem [TABLE_SIZE];
  bit                        tree_written [TABLE_SIZE];
  int                        written_list [$];
  logic [hufd_pkg::IDXW-1:0] walk_pos = '0;
  logic [hufd_pkg::IDXW-1:0] root_sel = '0;
  logic [hufd_pkg::CNTW-1:0] symbol_count = '0;
  logic [hufd_pkg::CNTW-1:0] symbol_total = '0;

  // Symbols still owed by the decoder, oldest first.
  hufd_pkg::res_t pending_symbols [$];
  hufd_pkg::res_t head_sym;
  int             err_count = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;

  huffman_tree_walk_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (op_i),
    .packed_byte_i (packed_byte_i),
    .node_index_i  (node_index_i),
    .node_is_leaf_i(node_is_leaf_i),
    .node_symbol_i (node_symbol_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .symbol_o      (symbol_o),
    .last_o        (last_o),
    .done_res_o    (done_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the decoder hangs.
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // A table load updates one entry of the shadow tree.
  task automatic store_tree_node(input tree_req_t r);
    tree_mem[r.idx] = '{leaf: r.leaf, sym: r.sym, kid0: r.kid0, kid1: r.kid1};
    if (!tree_written[r.idx]) begin
      tree_written[r.idx] = 1'b1;
      written_list.push_back(int'(r.idx));
    end
  endtask

  // Walk the shadow tree for one packed byte and queue the symbols it yields.
  task automatic walk_tree_byte(input logic [hufd_pkg::SYMW-1:0] data);
    hufd_pkg::node_t here;
    hufd_pkg::node_t nxt;
    hufd_pkg::res_t  r;
    hufd_pkg::res_t  batch [$];
    int              b;
    if (symbol_count >= symbol_total) return;
    for (b = hufd_pkg::BYTE_BITS - 1; b >= 0; b--) begin
      here = tree_mem[walk_pos];
      walk_pos = data[b] ? here.kid1 : here.kid0;
      nxt = tree_mem[walk_pos];
      if (nxt.leaf) begin
        symbol_count = symbol_count + 31'd1;
        walk_pos = root_sel;
        r.sym  = nxt.sym;
        r.last = 1'b0;
        r.done = (symbol_count >= symbol_total);
        batch.push_back(r);
        if (r.done) break;
      end
    end
    if (batch.size() > 0) begin
      r = batch.pop_back();
      r.last = 1'b1;
      batch.push_back(r);
    end
    foreach (batch[i]) pending_symbols.push_back(batch[i]);
  endtask

  // A request with every field random; callers override what matters.
  function automatic tree_req_t random_req();
    tree_req_t r;
    r.op        = 1'($urandom_range(1));
    r.data_byte = hufd_pkg::SYMW'($urandom_range(255));
    r.idx       = hufd_pkg::IDXW'($urandom_range(TABLE_SIZE - 1));
    r.leaf      = 1'($urandom_range(1));
    r.sym       = hufd_pkg::SYMW'($urandom_range(255));
    r.kid0      = hufd_pkg::IDXW'($urandom_range(TABLE_SIZE - 1));
    r.kid1      = hufd_pkg::IDXW'($urandom_range(TABLE_SIZE - 1));
    return r;
  endfunction

  // Offer one request, idling first at the current rate, and predict on acceptance.
  task automatic send_request(input tree_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    op_i           <= r.op;
    packed_byte_i  <= r.data_byte;
    node_index_i   <= r.idx;
    node_is_leaf_i <= r.leaf;
    node_symbol_i  <= r.sym;
    left_index_i   <= r.kid0;
    right_index_i  <= r.kid1;
    do @(posedge clk_i); while (full);
    if (r.op == hufd_pkg::OP_LOAD) store_tree_node(r);
    else walk_tree_byte(r.data_byte);
  endtask

  task automatic send_decode(input logic [hufd_pkg::SYMW-1:0] data);
    tree_req_t r;
    r = random_req();
    r.op = hufd_pkg::OP_DECODE;
    r.data_byte = data;
    send_request(r);
  endtask

  // Child index for a stray load: itself or any entry that already holds data.
  function automatic logic [hufd_pkg::IDXW-1:0] pick_written(
      input logic [hufd_pkg::IDXW-1:0] self_idx);
    if (written_list.size() == 0 || $urandom_range(3) == 0) return self_idx;
    return hufd_pkg::IDXW'(written_list[$urandom_range(written_list.size() - 1)]);
  endfunction

  // Stop sending and wait until the decoder has gone quiet.
  task automatic settle_block();
    push <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [hufd_pkg::CFG_IDXW-1:0] idx,
                           input logic [hufd_pkg::CFG_DW-1:0] val);
    settle_block();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == hufd_pkg::REG_ROOT) begin
      root_sel = val[hufd_pkg::IDXW-1:0];
      walk_pos = val[hufd_pkg::IDXW-1:0];
    end else begin
      symbol_total = val[hufd_pkg::CNTW-1:0];
    end
  endtask

  // Load a random code tree with n_leaves leaves and point the root at it.
  // Every child index names a node of this tree, so a walk never leaves written entries.
  // A negative forced_root lets the root land anywhere.
  task automatic build_tree(input int n_leaves, input int forced_root);
    bit        taken [TABLE_SIZE];
    int        pool [$];
    int        made [$];
    tree_req_t r;
    int        c;
    int        k;
    int        idx;
    foreach (taken[i]) taken[i] = 1'b0;
    if (forced_root >= 0) taken[forced_root] = 1'b1;
    for (c = 0; c < 2 * n_leaves - 1; c++) begin
      if (c == 2 * n_leaves - 2 && forced_root >= 0) begin
        idx = forced_root;
      end else begin
        do idx = int'($urandom_range(TABLE_SIZE - 1)); while (taken[idx]);
        taken[idx] = 1'b1;
      end
      r = random_req();
      r.op  = hufd_pkg::OP_LOAD;
      r.idx = hufd_pkg::IDXW'(idx);
      made.push_back(idx);
      if (c < n_leaves) begin
        // Leaf children only matter when the cursor sits on a leaf root.
        r.leaf = 1'b1;
        r.kid0 = hufd_pkg::IDXW'(made[$urandom_range(made.size() - 1)]);
        r.kid1 = hufd_pkg::IDXW'(made[$urandom_range(made.size() - 1)]);
      end else begin
        r.leaf = 1'b0;
        k = int'($urandom_range(pool.size() - 1));
        r.kid0 = hufd_pkg::IDXW'(pool[k]);
        pool.delete(k);
        k = int'($urandom_range(pool.size() - 1));
        r.kid1 = hufd_pkg::IDXW'(pool[k]);
        pool.delete(k);
      end
      pool.push_back(idx);
      send_request(r);
    end
    write_reg(hufd_pkg::REG_ROOT, hufd_pkg::CFG_DW'(pool[0]));
  endtask

  // Total of zero from reset: decode requests are swallowed without output.
  task automatic test_idle_total();
    build_tree(2, 0);
    send_decode(8'h00);
    send_decode(8'hFF);
  endtask

  // Two-leaf tree: every bit ends a code, so each byte gives eight symbols.
  task automatic test_full_bytes();
    write_reg(hufd_pkg::REG_TOTAL, CNT_MAX);
    send_decode(8'h00);
    send_decode(8'hFF);
    send_decode(8'hA5);
  endtask

  // Deeper tree rooted at the top entry: codes straddle byte boundaries.
  task automatic test_deep_codes();
    build_tree(5, TABLE_SIZE - 1);
    send_decode(8'h00);
    send_decode(8'hFF);
    send_decode(8'h5A);
    send_decode(8'h3C);
  endtask

  // Reaching the total drops the rest of the byte; afterwards nothing more comes out.
  task automatic test_reaching_total();
    write_reg(hufd_pkg::REG_TOTAL, symbol_count + 31'd3);
    send_decode(8'hFF);
    send_decode(8'h00);
    send_decode(8'h96);
    write_reg(hufd_pkg::REG_TOTAL, '0);
    send_decode(8'h69);
  endtask

  // Single-leaf tree: the cursor sits on a leaf and still follows its children.
  task automatic test_leaf_root();
    build_tree(1, -1);
    write_reg(hufd_pkg::REG_TOTAL, CNT_MAX);
    send_decode(8'h96);
    send_decode(8'h0F);
  endtask

  // Fresh trees with random bytes, a few stray loads and now and then a small total.
  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    tree_req_t r;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (3) begin
      build_tree(int'($urandom_range(2, 10)), -1);
      if ($urandom_range(2) == 0) begin
        write_reg(hufd_pkg::REG_TOTAL,
                  hufd_pkg::CNTW'(symbol_count + $urandom_range(1, 24)));
      end else begin
        write_reg(hufd_pkg::REG_TOTAL, CNT_MAX);
      end
      repeat (11) begin
        if ($urandom_range(9) == 0) begin
          r = random_req();
          r.op   = hufd_pkg::OP_LOAD;
          r.kid0 = pick_written(r.idx);
          r.kid1 = pick_written(r.idx);
          send_request(r);
        end else begin
          send_decode(hufd_pkg::SYMW'($urandom_range(255)));
        end
      end
    end
  endtask

  // Receiver side: pop at the current rate.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expected symbol.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_symbols.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result: symbol %0h last %0b done %0b",
                   symbol_o, last_o, done_res_o);
      end else begin
        head_sym = pending_symbols.pop_front();
        if (symbol_o !== head_sym.sym || last_o !== head_sym.last ||
            done_res_o !== head_sym.done) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("mismatch: expected symbol %0h last %0b done %0b, got %0h %0b %0b",
                     head_sym.sym, head_sym.last, head_sym.done,
                     symbol_o, last_o, done_res_o);
        end
      end
    end
  end

  initial begin
    // Assert reset with a falling edge so that the asynchronous reset takes effect at once.
    rst_ni <= 1'b0;
    foreach (tree_written[i]) tree_written[i] = 1'b0;
    foreach (tree_mem[i]) tree_mem[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_total();
    test_full_bytes();
    test_deep_codes();
    test_reaching_total();
    test_leaf_root();
    test_random_traffic(33, 61);
    test_random_traffic(61, 33);
    test_random_traffic(0, 0);

    settle_block();
    if (err_count == 0 && pending_symbols.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
